// ===== rtl/htok_pkg.sv =====
// Shared types, constants and helper functions of the markup tokenizer.
package htok_pkg;

  localparam int HOLD_DEPTH_DEF = 8;
  localparam int HOLD_LIMIT     = 10;
  localparam int MATCH_DEPTH    = 6;
  localparam int PRE_MAX        = 10;
  localparam int TAIL_MAX       = 4;
  localparam int QUEUE_DEPTH    = 4;

  localparam logic [7:0] CH_NUL   = 8'h00;
  localparam logic [7:0] CH_TAB   = 8'h09;
  localparam logic [7:0] CH_LF    = 8'h0A;
  localparam logic [7:0] CH_FF    = 8'h0C;
  localparam logic [7:0] CH_CR    = 8'h0D;
  localparam logic [7:0] CH_SP    = 8'h20;
  localparam logic [7:0] CH_BANG  = 8'h21;
  localparam logic [7:0] CH_DQ    = 8'h22;
  localparam logic [7:0] CH_SQ    = 8'h27;
  localparam logic [7:0] CH_DASH  = 8'h2D;
  localparam logic [7:0] CH_SLASH = 8'h2F;
  localparam logic [7:0] CH_LT    = 8'h3C;
  localparam logic [7:0] CH_EQ    = 8'h3D;
  localparam logic [7:0] CH_GT    = 8'h3E;
  localparam logic [7:0] CH_UC_A  = 8'h41;
  localparam logic [7:0] CH_UC_Z  = 8'h5A;
  localparam logic [7:0] CH_LC_A  = 8'h61;
  localparam logic [7:0] CH_LC_Z  = 8'h7A;
  localparam logic [7:0] CASE_BIT = 8'h20;

  typedef enum logic [3:0] {
    EV_TEXT          = 4'd0,
    EV_TEXT_END      = 4'd1,
    EV_START_BEGIN   = 4'd2,
    EV_END_BEGIN     = 4'd3,
    EV_NAME          = 4'd4,
    EV_ANAME         = 4'd5,
    EV_AVALUE        = 4'd6,
    EV_ATTR_KEEP     = 4'd7,
    EV_ATTR_DROP     = 4'd8,
    EV_TAG_END       = 4'd9,
    EV_TAG_ABORT     = 4'd10,
    EV_COMMENT       = 4'd11,
    EV_COMMENT_END   = 4'd12,
    EV_DOCTYPE       = 4'd13,
    EV_DOCTYPE_END   = 4'd14
  } ev_kind_t;

  typedef enum logic [4:0] {
    PS_DATA            = 5'd0,
    PS_TAG_OPEN        = 5'd1,
    PS_TAG_NAME        = 5'd2,
    PS_END_TAG_OPEN    = 5'd3,
    PS_SELF_CLOSING    = 5'd4,
    PS_BEFORE_ANAME    = 5'd5,
    PS_ANAME           = 5'd6,
    PS_AFTER_ANAME     = 5'd7,
    PS_BEFORE_AVALUE   = 5'd8,
    PS_VALUE_DQ        = 5'd9,
    PS_VALUE_SQ        = 5'd10,
    PS_VALUE_UNQ       = 5'd11,
    PS_AFTER_VALUE_Q   = 5'd12,
    PS_AFTER_VALUE_UNQ = 5'd13,
    PS_MARKUP          = 5'd14,
    PS_COMMENT         = 5'd15,
    PS_DOCTYPE         = 5'd16
  } ps_t;

  typedef enum logic [1:0] {
    PRE_NONE   = 2'd0,
    PRE_MARKUP = 2'd1,
    PRE_HELD   = 2'd2,
    PRE_DASH   = 2'd3
  } pre_src_t;

  typedef struct packed {
    logic [7:0] in_byte;
    logic       in_last;
  } in_item_t;

  typedef struct packed {
    logic [3:0] event_kind;
    logic [7:0] event_byte;
    logic       self_closing;
    logic       out_last;
  } out_item_t;

  typedef struct packed {
    ev_kind_t   kind;
    logic [7:0] ebyte;
    logic       sc;
  } ev_t;

  // One input byte's burst: a run of same-kind bytes, then a few single events.
  typedef struct packed {
    logic [3:0]                    pre_n;
    ev_kind_t                      pre_kind;
    logic [PRE_MAX-1:0][7:0]       pre_bytes;
    logic [2:0]                    tl_n;
    ev_t [TAIL_MAX-1:0]            tl;
  } desc_t;

  function automatic int hold_cap(int depth);
    return (depth < 1) ? 1 : ((depth > HOLD_LIMIT) ? HOLD_LIMIT : depth);
  endfunction

  function automatic ev_t mk_ev(ev_kind_t kind, logic [7:0] b, logic sc);
    ev_t e;
    e.kind  = kind;
    e.ebyte = b;
    e.sc    = sc;
    return e;
  endfunction

endpackage

// ===== rtl/htok_front.sv =====
// Front end: tokenizer state update and per-byte event burst descriptor.
module htok_front import htok_pkg::*; #(
  parameter int HOLD_DEPTH = HOLD_DEPTH_DEF
) (
  input  logic     clk,
  input  logic     rst,
  input  logic     byte_valid,
  output logic     byte_stall,
  input  in_item_t byte_item,
  output logic     push,
  output desc_t    push_desc,
  input  logic     q_full
);

  localparam int HOLD_CAP = hold_cap(HOLD_DEPTH);
  localparam int HCW      = $clog2(HOLD_CAP + 1);
  localparam int HIW      = (HOLD_CAP > 1) ? $clog2(HOLD_CAP) : 1;
  localparam int MAX_PASS = 4;

  ps_t            parse_state, parse_state_next;
  logic [2:0]     match_count, match_count_next;
  logic [1:0]     dash_run, dash_run_next;
  logic           text_pending, text_pending_next;
  logic           attr_name_pending, attr_name_pending_next;
  logic           attr_value_pending, attr_value_pending_next;
  logic           doctype_started, doctype_started_next;
  logic [HCW-1:0] held_count, held_count_next;
  logic [7:0]     match_bytes [MATCH_DEPTH];
  logic [7:0]     match_bytes_next [MATCH_DEPTH];
  logic [7:0]     held_space [HOLD_CAP];
  logic [7:0]     held_space_next [HOLD_CAP];

  logic [7:0] c;
  logic       accept;
  logic       again, do_store, do_drop, fin, fin_sc, do_flush;
  logic [2:0] tn;
  pre_src_t   pre_src;
  desc_t      d;

  function automatic logic is_ws(logic [7:0] b);
    return (b == CH_SP) || (b == CH_TAB) || (b == CH_LF) || (b == CH_CR) || (b == CH_FF);
  endfunction

  function automatic logic is_alpha(logic [7:0] b);
    return (b inside {[CH_UC_A:CH_UC_Z], [CH_LC_A:CH_LC_Z]});
  endfunction

  // Lower-case letters of the doctype keyword, by match position.
  function automatic logic [7:0] dt_char(logic [2:0] i);
    logic [7:0] r;
    case (i)
      3'd0:    r = 8'h64;
      3'd1:    r = 8'h6F;
      3'd2:    r = 8'h63;
      3'd3:    r = 8'h74;
      3'd4:    r = 8'h79;
      3'd5:    r = 8'h70;
      3'd6:    r = 8'h65;
      default: r = CH_NUL;
    endcase
    return r;
  endfunction

  assign c          = byte_item.in_byte;
  assign byte_stall = q_full;
  assign accept     = byte_valid && !q_full;

  always_comb begin
    parse_state_next        = parse_state;
    match_count_next        = match_count;
    dash_run_next           = dash_run;
    text_pending_next       = text_pending;
    attr_name_pending_next  = attr_name_pending;
    attr_value_pending_next = attr_value_pending;
    doctype_started_next    = doctype_started;
    held_count_next         = held_count;
    match_bytes_next        = match_bytes;
    held_space_next         = held_space;
    d        = '0;
    tn       = '0;
    pre_src  = PRE_NONE;
    again    = 1'b1;
    do_store = 1'b0;
    do_drop  = 1'b0;
    fin      = 1'b0;
    fin_sc   = 1'b0;
    do_flush = 1'b0;

    // A byte may be handed on to the next state; at most three hand-offs occur.
    for (int pass = 0; pass < MAX_PASS; pass++) begin
      if (again) begin
        again    = 1'b0;
        do_store = 1'b0;
        do_drop  = 1'b0;
        fin      = 1'b0;
        fin_sc   = 1'b0;
        do_flush = 1'b0;
        case (parse_state_next)
          PS_DATA: begin
            if (c == CH_LT) begin
              if (text_pending_next) begin
                d.tl[tn[1:0]] = mk_ev(EV_TEXT_END, CH_NUL, 1'b0);
                tn = tn + 3'd1;
              end
              text_pending_next = 1'b0;
              parse_state_next  = PS_TAG_OPEN;
            end else begin
              d.tl[tn[1:0]] = mk_ev(EV_TEXT, c, 1'b0);
              tn = tn + 3'd1;
              text_pending_next = 1'b1;
            end
          end
          PS_TAG_OPEN: begin
            if (c == CH_SLASH) begin
              parse_state_next = PS_END_TAG_OPEN;
            end else if (is_alpha(c)) begin
              attr_name_pending_next  = 1'b0;
              attr_value_pending_next = 1'b0;
              d.tl[tn[1:0]] = mk_ev(EV_START_BEGIN, c, 1'b0);
              tn = tn + 3'd1;
              parse_state_next = PS_TAG_NAME;
            end else if (c == CH_BANG) begin
              match_count_next = '0;
              parse_state_next = PS_MARKUP;
            end else begin
              d.tl[tn[1:0]] = mk_ev(EV_TEXT, CH_LT, 1'b0);
              tn = tn + 3'd1;
              text_pending_next = 1'b1;
              parse_state_next  = PS_DATA;
              again = 1'b1;
            end
          end
          PS_TAG_NAME: begin
            if (is_ws(c)) begin
              parse_state_next = PS_BEFORE_ANAME;
            end else if (c == CH_SLASH) begin
              parse_state_next = PS_SELF_CLOSING;
            end else if (c == CH_GT) begin
              fin = 1'b1;
            end else begin
              d.tl[tn[1:0]] = mk_ev(EV_NAME, c, 1'b0);
              tn = tn + 3'd1;
            end
          end
          PS_END_TAG_OPEN: begin
            if (is_alpha(c)) begin
              attr_name_pending_next  = 1'b0;
              attr_value_pending_next = 1'b0;
              d.tl[tn[1:0]] = mk_ev(EV_END_BEGIN, c, 1'b0);
              tn = tn + 3'd1;
              parse_state_next = PS_TAG_NAME;
            end else begin
              parse_state_next = PS_DATA;
            end
          end
          PS_SELF_CLOSING: begin
            if (c == CH_GT) begin
              fin    = 1'b1;
              fin_sc = 1'b1;
            end else begin
              parse_state_next = PS_BEFORE_ANAME;
              again = 1'b1;
            end
          end
          PS_BEFORE_ANAME: begin
            if (!is_ws(c)) begin
              if (c == CH_SLASH || c == CH_GT) begin
                parse_state_next = PS_AFTER_ANAME;
              end else begin
                do_drop = 1'b1;
                parse_state_next = PS_ANAME;
              end
              again = 1'b1;
            end
          end
          PS_ANAME: begin
            if (is_ws(c) || c == CH_SLASH || c == CH_GT) begin
              parse_state_next = PS_AFTER_ANAME;
              again = 1'b1;
            end else if (c == CH_EQ) begin
              parse_state_next = PS_BEFORE_AVALUE;
            end else begin
              d.tl[tn[1:0]] = mk_ev(EV_ANAME, c, 1'b0);
              tn = tn + 3'd1;
              attr_name_pending_next = 1'b1;
            end
          end
          PS_AFTER_ANAME: begin
            if (!is_ws(c)) begin
              if (c == CH_SLASH) begin
                parse_state_next = PS_SELF_CLOSING;
              end else if (c == CH_EQ) begin
                parse_state_next = PS_BEFORE_AVALUE;
              end else if (c == CH_GT) begin
                do_store = 1'b1;
                fin      = 1'b1;
              end else begin
                do_store = 1'b1;
                parse_state_next = PS_ANAME;
                again = 1'b1;
              end
            end
          end
          PS_BEFORE_AVALUE: begin
            if (!is_ws(c)) begin
              if (c == CH_DQ) begin
                parse_state_next = PS_VALUE_DQ;
              end else if (c == CH_SQ) begin
                parse_state_next = PS_VALUE_SQ;
              end else if (c == CH_GT) begin
                do_store = 1'b1;
                fin      = 1'b1;
              end else begin
                parse_state_next = PS_VALUE_UNQ;
                again = 1'b1;
              end
            end
          end
          PS_VALUE_DQ, PS_VALUE_SQ: begin
            if (c == ((parse_state_next == PS_VALUE_DQ) ? CH_DQ : CH_SQ)) begin
              do_store = 1'b1;
              parse_state_next = PS_AFTER_VALUE_Q;
            end else begin
              d.tl[tn[1:0]] = mk_ev(EV_AVALUE, c, 1'b0);
              tn = tn + 3'd1;
              attr_value_pending_next = 1'b1;
            end
          end
          PS_VALUE_UNQ: begin
            if (is_ws(c)) begin
              do_store = 1'b1;
              parse_state_next = PS_AFTER_VALUE_UNQ;
            end else if (c == CH_GT) begin
              do_store = 1'b1;
              fin      = 1'b1;
            end else if (c != CH_NUL) begin
              d.tl[tn[1:0]] = mk_ev(EV_AVALUE, c, 1'b0);
              tn = tn + 3'd1;
              attr_value_pending_next = 1'b1;
            end
          end
          PS_AFTER_VALUE_Q, PS_AFTER_VALUE_UNQ: begin
            if (is_ws(c)) begin
              parse_state_next = PS_BEFORE_ANAME;
            end else if (c == CH_SLASH) begin
              parse_state_next = PS_SELF_CLOSING;
            end else if (c == CH_GT) begin
              fin = 1'b1;
            end else begin
              parse_state_next = PS_BEFORE_ANAME;
              again = 1'b1;
            end
          end
          PS_MARKUP: begin
            if (match_count_next == 3'd0) begin
              if (c == CH_DASH || (c | CASE_BIT) == dt_char(3'd0)) begin
                match_bytes_next[0] = c;
                match_count_next    = 3'd1;
              end else begin
                do_flush = 1'b1;
              end
            end else if (match_bytes_next[0] == CH_DASH) begin
              if (c == CH_DASH) begin
                match_count_next = '0;
                dash_run_next    = '0;
                parse_state_next = PS_COMMENT;
              end else begin
                do_flush = 1'b1;
              end
            end else if ((c | CASE_BIT) == dt_char(match_count_next)) begin
              if (match_count_next == 3'(MATCH_DEPTH)) begin
                match_count_next     = '0;
                held_count_next      = '0;
                doctype_started_next = 1'b0;
                parse_state_next     = PS_DOCTYPE;
              end else begin
                match_bytes_next[match_count_next] = c;
                match_count_next = match_count_next + 3'd1;
              end
            end else begin
              do_flush = 1'b1;
            end
          end
          PS_COMMENT: begin
            if (c == CH_DASH) begin
              if (dash_run_next != 2'd2) begin
                dash_run_next = dash_run_next + 2'd1;
              end else begin
                d.tl[tn[1:0]] = mk_ev(EV_COMMENT, CH_DASH, 1'b0);
                tn = tn + 3'd1;
              end
            end else if (c == CH_GT && dash_run_next == 2'd2) begin
              d.tl[tn[1:0]] = mk_ev(EV_COMMENT_END, CH_NUL, 1'b0);
              tn = tn + 3'd1;
              dash_run_next    = '0;
              parse_state_next = PS_DATA;
            end else begin
              pre_src       = PRE_DASH;
              d.pre_n       = 4'(dash_run_next);
              dash_run_next = '0;
              d.tl[tn[1:0]] = mk_ev(EV_COMMENT, c, 1'b0);
              tn = tn + 3'd1;
            end
          end
          PS_DOCTYPE: begin
            if (c == CH_GT) begin
              d.tl[tn[1:0]] = mk_ev(EV_DOCTYPE_END, CH_NUL, 1'b0);
              tn = tn + 3'd1;
              held_count_next      = '0;
              doctype_started_next = 1'b0;
              parse_state_next     = PS_DATA;
            end else if (is_ws(c)) begin
              if (doctype_started_next) begin
                if (held_count_next == HCW'(HOLD_CAP)) begin
                  // Store full: the oldest held byte leaks out.
                  d.tl[tn[1:0]] = mk_ev(EV_DOCTYPE, held_space[0], 1'b0);
                  tn = tn + 3'd1;
                  for (int i = 0; i < HOLD_CAP - 1; i++) begin
                    held_space_next[i] = held_space[i+1];
                  end
                  held_space_next[HOLD_CAP-1] = c;
                end else begin
                  held_space_next[held_count_next[HIW-1:0]] = c;
                  held_count_next = held_count_next + 1'b1;
                end
              end
            end else begin
              pre_src         = PRE_HELD;
              d.pre_n         = 4'(held_count_next);
              held_count_next = '0;
              d.tl[tn[1:0]] = mk_ev(EV_DOCTYPE, c, 1'b0);
              tn = tn + 3'd1;
              doctype_started_next = 1'b1;
            end
          end
          default: begin
            parse_state_next = PS_DATA;
            again = 1'b1;
          end
        endcase

        if (do_store) begin
          if (attr_name_pending_next) begin
            d.tl[tn[1:0]] = mk_ev(EV_ATTR_KEEP, CH_NUL, 1'b0);
            tn = tn + 3'd1;
          end else if (attr_value_pending_next) begin
            d.tl[tn[1:0]] = mk_ev(EV_ATTR_DROP, CH_NUL, 1'b0);
            tn = tn + 3'd1;
          end
          attr_name_pending_next  = 1'b0;
          attr_value_pending_next = 1'b0;
        end
        if (do_drop || fin) begin
          if (attr_name_pending_next || attr_value_pending_next) begin
            d.tl[tn[1:0]] = mk_ev(EV_ATTR_DROP, CH_NUL, 1'b0);
            tn = tn + 3'd1;
          end
          attr_name_pending_next  = 1'b0;
          attr_value_pending_next = 1'b0;
        end
        if (fin) begin
          d.tl[tn[1:0]] = mk_ev(EV_TAG_END, CH_NUL, fin_sc);
          tn = tn + 3'd1;
          parse_state_next = PS_DATA;
        end
        if (do_flush) begin
          pre_src           = PRE_MARKUP;
          d.pre_n           = 4'(match_count_next) + 4'd2;
          text_pending_next = 1'b1;
          match_count_next  = '0;
          parse_state_next  = PS_DATA;
          again = 1'b1;
        end
      end
    end

    // End of input: close whatever is open, then return to the reset state.
    if (byte_item.in_last) begin
      if (parse_state_next inside {PS_TAG_NAME, PS_SELF_CLOSING, PS_BEFORE_ANAME, PS_ANAME,
                                   PS_AFTER_ANAME, PS_BEFORE_AVALUE, PS_VALUE_DQ,
                                   PS_VALUE_SQ, PS_VALUE_UNQ, PS_AFTER_VALUE_Q,
                                   PS_AFTER_VALUE_UNQ}) begin
        if (attr_name_pending_next || attr_value_pending_next) begin
          d.tl[tn[1:0]] = mk_ev(EV_ATTR_DROP, CH_NUL, 1'b0);
          tn = tn + 3'd1;
        end
        d.tl[tn[1:0]] = mk_ev(EV_TAG_ABORT, CH_NUL, 1'b0);
        tn = tn + 3'd1;
      end else if (parse_state_next == PS_MARKUP) begin
        pre_src           = PRE_MARKUP;
        d.pre_n           = 4'(match_count_next) + 4'd2;
        text_pending_next = 1'b1;
      end else if (parse_state_next == PS_COMMENT) begin
        if (dash_run_next != 2'd0) begin
          pre_src = PRE_DASH;
          d.pre_n = 4'(dash_run_next);
        end
        d.tl[tn[1:0]] = mk_ev(EV_COMMENT_END, CH_NUL, 1'b0);
        tn = tn + 3'd1;
      end else if (parse_state_next == PS_DOCTYPE) begin
        d.tl[tn[1:0]] = mk_ev(EV_DOCTYPE_END, CH_NUL, 1'b0);
        tn = tn + 3'd1;
      end
      if (text_pending_next) begin
        d.tl[tn[1:0]] = mk_ev(EV_TEXT_END, CH_NUL, 1'b0);
        tn = tn + 3'd1;
      end
      parse_state_next        = PS_DATA;
      match_count_next        = '0;
      dash_run_next           = '0;
      text_pending_next       = 1'b0;
      attr_name_pending_next  = 1'b0;
      attr_value_pending_next = 1'b0;
      doctype_started_next    = 1'b0;
      held_count_next         = '0;
    end

    // The bytes of the leading run depend only on where they come from.
    case (pre_src)
      PRE_MARKUP: begin
        d.pre_kind     = EV_TEXT;
        d.pre_bytes[0] = CH_LT;
        d.pre_bytes[1] = CH_BANG;
        for (int i = 0; i < MATCH_DEPTH; i++) begin
          d.pre_bytes[i+2] = match_bytes_next[i];
        end
      end
      PRE_HELD: begin
        d.pre_kind = EV_DOCTYPE;
        for (int i = 0; i < HOLD_CAP; i++) begin
          d.pre_bytes[i] = held_space[i];
        end
      end
      PRE_DASH: begin
        d.pre_kind = EV_COMMENT;
        for (int i = 0; i < PRE_MAX; i++) begin
          d.pre_bytes[i] = CH_DASH;
        end
      end
      default: begin
        d.pre_kind = EV_TEXT;
      end
    endcase
    d.tl_n = tn;
  end

  assign push      = accept && ((d.pre_n != 4'd0) || (tn != 3'd0));
  assign push_desc = d;

  always_ff @(posedge clk) begin
    if (rst) begin
      parse_state        <= PS_DATA;
      match_count        <= '0;
      dash_run           <= '0;
      text_pending       <= 1'b0;
      attr_name_pending  <= 1'b0;
      attr_value_pending <= 1'b0;
      doctype_started    <= 1'b0;
      held_count         <= '0;
    end else if (accept) begin
      parse_state        <= parse_state_next;
      match_count        <= match_count_next;
      dash_run           <= dash_run_next;
      text_pending       <= text_pending_next;
      attr_name_pending  <= attr_name_pending_next;
      attr_value_pending <= attr_value_pending_next;
      doctype_started    <= doctype_started_next;
      held_count         <= held_count_next;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      match_bytes <= match_bytes_next;
      held_space  <= held_space_next;
    end
  end

endmodule

// ===== rtl/htok_queue.sv =====
// Short descriptor queue between the front end and the event sequencer.
module htok_queue import htok_pkg::*; (
  input  logic  clk,
  input  logic  rst,
  input  logic  push,
  input  desc_t push_desc,
  output logic  full,
  input  logic  pop,
  output logic  head_valid,
  output desc_t head
);

  localparam int QAW = $clog2(QUEUE_DEPTH);
  localparam int QCW = $clog2(QUEUE_DEPTH + 1);

  desc_t          entries [QUEUE_DEPTH];
  logic [QAW-1:0] wr_ptr;
  logic [QAW-1:0] rd_ptr;
  logic [QCW-1:0] count;

  assign full       = (count == QCW'(QUEUE_DEPTH));
  assign head_valid = (count != '0);
  assign head       = entries[rd_ptr];

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= rd_ptr + 1'b1;
      end
      if (push && !pop) begin
        count <= count + 1'b1;
      end else if (pop && !push) begin
        count <= count - 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      entries[wr_ptr] <= push_desc;
    end
  end

endmodule

// ===== rtl/htok_back.sv =====
// Back end: expands each descriptor into events, one transfer per cycle while the output is not stalled.
module htok_back import htok_pkg::*; (
  input  logic      clk,
  input  logic      rst,
  input  logic      head_valid,
  input  desc_t     head,
  output logic      pop,
  output logic      event_valid,
  input  logic      event_stall,
  output out_item_t event_item
);

  logic [3:0] idx;
  logic [3:0] total;
  logic [3:0] tidx;
  logic       load;
  logic       is_end;
  ev_t        tail_ev;
  out_item_t  next_item;

  assign load    = head_valid && (!event_valid || !event_stall);
  assign total   = head.pre_n + 4'(head.tl_n);
  assign is_end  = (idx == total - 4'd1);
  assign pop     = load && is_end;
  assign tidx    = idx - head.pre_n;
  assign tail_ev = head.tl[tidx[1:0]];

  always_comb begin
    if (idx < head.pre_n) begin
      next_item.event_kind   = head.pre_kind;
      next_item.event_byte   = head.pre_bytes[idx];
      next_item.self_closing = 1'b0;
    end else begin
      next_item.event_kind   = tail_ev.kind;
      next_item.event_byte   = tail_ev.ebyte;
      next_item.self_closing = tail_ev.sc;
    end
    next_item.out_last = is_end;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      event_valid <= 1'b0;
      idx         <= '0;
    end else if (load) begin
      event_valid <= 1'b1;
      idx         <= is_end ? 4'd0 : idx + 4'd1;
    end else if (!event_stall) begin
      event_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      event_item <= next_item;
    end
  end

endmodule

// ===== rtl/html_markup_tokenizer_unit.sv =====
// An event reaches the output through the descriptor queue and then the output register.
// Throughput: one byte per cycle into a 4-entry descriptor queue while it is not full;
//   the output port moves one event per cycle while it is not stalled.
// A byte causes 0 to 12 events; the output register sets the sustained rate.
// Reset (rst, synchronous, active high) returns the tokenizer to the data state
//   and empties the queue and output register; no clearing pass is needed.
module html_markup_tokenizer_unit import htok_pkg::*; #(
  parameter int HOLD_DEPTH = HOLD_DEPTH_DEF
) (
  input  logic      clk,
  input  logic      rst,
  input  logic      byte_valid,
  output logic      byte_stall,
  input  in_item_t  byte_item,
  output logic      event_valid,
  input  logic      event_stall,
  output out_item_t event_item
);

  // The front end updates the tokenizer state for every accepted byte and, when
  // the byte causes events, writes a descriptor of the resulting event burst into the queue.
  // It stalls the byte channel only when the queue is full.
  logic  push;
  desc_t push_desc;
  logic  q_full;

  // The back end walks the descriptor at the queue head, one event per
  // transfer, and pops it after the last event of the burst.
  logic  pop;
  logic  head_valid;
  desc_t head;

  htok_front #(
    .HOLD_DEPTH(HOLD_DEPTH)
  ) u_front (
    .clk        (clk),
    .rst        (rst),
    .byte_valid (byte_valid),
    .byte_stall (byte_stall),
    .byte_item  (byte_item),
    .push       (push),
    .push_desc  (push_desc),
    .q_full     (q_full)
  );

  htok_queue u_queue (
    .clk        (clk),
    .rst        (rst),
    .push       (push),
    .push_desc  (push_desc),
    .full       (q_full),
    .pop        (pop),
    .head_valid (head_valid),
    .head       (head)
  );

  // The output register lets the front end keep taking bytes while a
  // finished event waits for its transfer.
  htok_back u_back (
    .clk         (clk),
    .rst         (rst),
    .head_valid  (head_valid),
    .head        (head),
    .pop         (pop),
    .event_valid (event_valid),
    .event_stall (event_stall),
    .event_item  (event_item)
  );

endmodule

// ===== rtl/htok_checker.sv =====
// Port-level checks of the tokenizer output channel and of the byte channel after reset, bound to the top level.
module htok_checker import htok_pkg::*; (
  input logic      clk,
  input logic      rst,
  input logic      byte_valid,
  input logic      byte_stall,
  input out_item_t event_item,
  input logic      event_valid,
  input logic      event_stall
);

  a_hold: assert property (@(posedge clk) disable iff (rst)
    event_valid && event_stall |=> event_valid && $stable(event_item))
    else $error("stalled event changed");

  a_kind: assert property (@(posedge clk) disable iff (rst)
    event_valid |-> event_item.event_kind <= EV_DOCTYPE_END)
    else $error("event kind out of range");

  a_sc: assert property (@(posedge clk) disable iff (rst)
    event_valid && event_item.self_closing |-> event_item.event_kind == EV_TAG_END)
    else $error("self-closing flag on a non tag-end event");

  a_zero: assert property (@(posedge clk) disable iff (rst)
    event_valid && (event_item.event_kind == EV_TEXT_END ||
                    event_item.event_kind == EV_TAG_END ||
                    event_item.event_kind == EV_ATTR_KEEP) |-> event_item.event_byte == 8'h00)
    else $error("marker event carries a byte");

  // The queue is empty right after reset, so the byte channel is open.
  a_open: assert property (@(posedge clk)
    $past(rst) && !rst |-> !byte_stall)
    else $error("byte channel stalled right after reset, valid=%b", byte_valid);

endmodule

bind html_markup_tokenizer_unit htok_checker u_chk (.*);

// ===== tb/tb_top.sv =====
// Self-checking testbench for the markup tokenizer: directed and random byte streams.
module tb_top;
  import htok_pkg::*;

  // The predictor models the tokenizer byte by byte. Each accepted byte adds its
  // events to the queue of pending events, and each event that comes out of the
  // block is checked against the oldest pending one.
  class event_scoreboard;
    out_item_t pending_events[$];
    int unsigned errors;
    int unsigned events_seen;
    ps_t st;
    int mcount;
    logic [7:0] mbytes[6];
    int dashes;
    bit text_open, name_open, value_open, dt_started;
    logic [7:0] held[10];
    int held_n;
    int cap;
    out_item_t burst[$];

    function new(int depth);
      cap = hold_cap(depth);
      errors = 0;
      events_seen = 0;
      clear_state();
    endfunction

    function void clear_state();
      st = PS_DATA;
      mcount = 0;
      dashes = 0;
      text_open = 0;
      name_open = 0;
      value_open = 0;
      dt_started = 0;
      held_n = 0;
    endfunction

    function void push(ev_kind_t k, logic [7:0] b, logic sc);
      out_item_t e;
      if (burst.size() < 12) begin
        e.event_kind = k;
        e.event_byte = b;
        e.self_closing = sc;
        e.out_last = 1'b0;
        burst.insert(burst.size(), e);
      end
    endfunction

    function bit is_space(logic [7:0] c);
      return c == CH_SP || c == CH_TAB || c == CH_LF || c == CH_CR || c == CH_FF;
    endfunction

    function bit is_letter(logic [7:0] c);
      return (c >= CH_UC_A && c <= CH_UC_Z) || (c >= CH_LC_A && c <= CH_LC_Z);
    endfunction

    function void text(logic [7:0] c);
      push(EV_TEXT, c, 0);
      text_open = 1;
    endfunction

    function void close_text();
      if (text_open) push(EV_TEXT_END, 0, 0);
      text_open = 0;
    endfunction

    function void keep_attr();
      if (name_open) push(EV_ATTR_KEEP, 0, 0);
      else if (value_open) push(EV_ATTR_DROP, 0, 0);
      name_open = 0;
      value_open = 0;
    endfunction

    function void lose_attr();
      if (name_open || value_open) push(EV_ATTR_DROP, 0, 0);
      name_open = 0;
      value_open = 0;
    endfunction

    function void close_tag(logic sc);
      lose_attr();
      push(EV_TAG_END, 0, sc);
      st = PS_DATA;
    endfunction

    // A failed "<!" lookahead turns everything it swallowed back into text.
    function void flush_markup();
      text(CH_LT);
      text(CH_BANG);
      for (int i = 0; i < mcount; i++) text(mbytes[i]);
      mcount = 0;
      st = PS_DATA;
    endfunction

    function bit markup_step(logic [7:0] c);
      logic [7:0] word[7];
      word = '{"d", "o", "c", "t", "y", "p", "e"};
      if (mcount == 0) begin
        if (c == CH_DASH || (c | CASE_BIT) == "d") begin
          mbytes[0] = c;
          mcount = 1;
          return 0;
        end
      end else if (mbytes[0] == CH_DASH) begin
        if (c == CH_DASH) begin
          mcount = 0;
          dashes = 0;
          st = PS_COMMENT;
          return 0;
        end
      end else if (mcount < 7 && (c | CASE_BIT) == word[mcount]) begin
        if (mcount == 6) begin
          mcount = 0;
          held_n = 0;
          dt_started = 0;
          st = PS_DOCTYPE;
        end else begin
          mbytes[mcount] = c;
          mcount++;
        end
        return 0;
      end
      flush_markup();
      return 1;
    endfunction

    function void comment_step(logic [7:0] c);
      if (c == CH_DASH) begin
        if (dashes < 2) dashes++;
        else push(EV_COMMENT, CH_DASH, 0);
      end else if (c == CH_GT && dashes == 2) begin
        push(EV_COMMENT_END, 0, 0);
        dashes = 0;
        st = PS_DATA;
      end else begin
        for (int i = 0; i < dashes; i++) push(EV_COMMENT, CH_DASH, 0);
        dashes = 0;
        push(EV_COMMENT, c, 0);
      end
    endfunction

    // Doctype text is trimmed: leading whitespace is dropped, trailing whitespace
    // is held until a visible byte proves it was interior.
    function void doctype_step(logic [7:0] c);
      if (c == CH_GT) begin
        push(EV_DOCTYPE_END, 0, 0);
        held_n = 0;
        dt_started = 0;
        st = PS_DATA;
      end else if (is_space(c)) begin
        if (!dt_started) return;
        if (held_n >= cap) begin
          push(EV_DOCTYPE, held[0], 0);
          for (int i = 0; i < cap - 1; i++) held[i] = held[i+1];
          held_n = cap - 1;
        end
        held[held_n] = c;
        held_n++;
      end else begin
        for (int i = 0; i < held_n; i++) push(EV_DOCTYPE, held[i], 0);
        held_n = 0;
        push(EV_DOCTYPE, c, 0);
        dt_started = 1;
      end
    endfunction

    function void consume(logic [7:0] c);
      bit again;
      again = 1;
      while (again) begin
        again = 0;
        case (st)
          PS_DATA: begin
            if (c == CH_LT) begin
              close_text();
              st = PS_TAG_OPEN;
            end else text(c);
          end
          PS_TAG_OPEN: begin
            if (c == CH_SLASH) st = PS_END_TAG_OPEN;
            else if (is_letter(c)) begin
              name_open = 0;
              value_open = 0;
              push(EV_START_BEGIN, c, 0);
              st = PS_TAG_NAME;
            end else if (c == CH_BANG) begin
              mcount = 0;
              st = PS_MARKUP;
            end else begin
              text(CH_LT);
              st = PS_DATA;
              again = 1;
            end
          end
          PS_TAG_NAME: begin
            if (is_space(c)) st = PS_BEFORE_ANAME;
            else if (c == CH_SLASH) st = PS_SELF_CLOSING;
            else if (c == CH_GT) close_tag(0);
            else push(EV_NAME, c, 0);
          end
          PS_END_TAG_OPEN: begin
            if (is_letter(c)) begin
              name_open = 0;
              value_open = 0;
              push(EV_END_BEGIN, c, 0);
              st = PS_TAG_NAME;
            end else st = PS_DATA;
          end
          PS_SELF_CLOSING: begin
            if (c == CH_GT) close_tag(1);
            else begin
              st = PS_BEFORE_ANAME;
              again = 1;
            end
          end
          PS_BEFORE_ANAME: begin
            if (!is_space(c)) begin
              if (c == CH_SLASH || c == CH_GT) st = PS_AFTER_ANAME;
              else begin
                lose_attr();
                st = PS_ANAME;
              end
              again = 1;
            end
          end
          PS_ANAME: begin
            if (is_space(c) || c == CH_SLASH || c == CH_GT) begin
              st = PS_AFTER_ANAME;
              again = 1;
            end else if (c == CH_EQ) st = PS_BEFORE_AVALUE;
            else begin
              push(EV_ANAME, c, 0);
              name_open = 1;
            end
          end
          PS_AFTER_ANAME: begin
            if (!is_space(c)) begin
              if (c == CH_SLASH) st = PS_SELF_CLOSING;
              else if (c == CH_EQ) st = PS_BEFORE_AVALUE;
              else if (c == CH_GT) begin
                keep_attr();
                close_tag(0);
              end else begin
                keep_attr();
                st = PS_ANAME;
                again = 1;
              end
            end
          end
          PS_BEFORE_AVALUE: begin
            if (!is_space(c)) begin
              if (c == CH_DQ) st = PS_VALUE_DQ;
              else if (c == CH_SQ) st = PS_VALUE_SQ;
              else if (c == CH_GT) begin
                keep_attr();
                close_tag(0);
              end else begin
                st = PS_VALUE_UNQ;
                again = 1;
              end
            end
          end
          PS_VALUE_DQ, PS_VALUE_SQ: begin
            if (c == ((st == PS_VALUE_DQ) ? CH_DQ : CH_SQ)) begin
              keep_attr();
              st = PS_AFTER_VALUE_Q;
            end else begin
              push(EV_AVALUE, c, 0);
              value_open = 1;
            end
          end
          PS_VALUE_UNQ: begin
            if (is_space(c)) begin
              keep_attr();
              st = PS_AFTER_VALUE_UNQ;
            end else if (c == CH_GT) begin
              keep_attr();
              close_tag(0);
            end else if (c != CH_NUL) begin
              push(EV_AVALUE, c, 0);
              value_open = 1;
            end
          end
          PS_AFTER_VALUE_Q, PS_AFTER_VALUE_UNQ: begin
            if (is_space(c)) st = PS_BEFORE_ANAME;
            else if (c == CH_SLASH) st = PS_SELF_CLOSING;
            else if (c == CH_GT) close_tag(0);
            else begin
              st = PS_BEFORE_ANAME;
              again = 1;
            end
          end
          PS_MARKUP: again = markup_step(c);
          PS_COMMENT: comment_step(c);
          PS_DOCTYPE: doctype_step(c);
          default: begin
            st = PS_DATA;
            again = 1;
          end
        endcase
      end
    endfunction

    function void end_of_input();
      if (st == PS_TAG_NAME || (st >= PS_SELF_CLOSING && st <= PS_AFTER_VALUE_UNQ)) begin
        lose_attr();
        push(EV_TAG_ABORT, 0, 0);
      end else if (st == PS_MARKUP) flush_markup();
      else if (st == PS_COMMENT) begin
        for (int i = 0; i < dashes; i++) push(EV_COMMENT, CH_DASH, 0);
        push(EV_COMMENT_END, 0, 0);
      end else if (st == PS_DOCTYPE) push(EV_DOCTYPE_END, 0, 0);
      close_text();
    endfunction

    // Note one accepted input transfer and queue the events it causes.
    function void note_byte(in_item_t it);
      burst.delete();
      consume(it.in_byte);
      if (it.in_last) begin
        end_of_input();
        clear_state();
      end
      if (burst.size() > 0) burst[burst.size()-1].out_last = 1'b1;
      foreach (burst[i]) pending_events.insert(pending_events.size(), burst[i]);
    endfunction

    // Compare one accepted output transfer with the oldest pending event.
    function void check_event(out_item_t got);
      out_item_t want;
      events_seen++;
      if (pending_events.size() == 0) begin
        $error("unexpected event kind=%0d byte=%h", got.event_kind, got.event_byte);
        errors++;
        return;
      end
      want = pending_events.pop_front();
      if (got.event_kind !== want.event_kind) begin
        $error("event_kind: expected %0d, got %0d", want.event_kind, got.event_kind);
        errors++;
      end
      if (got.event_byte !== want.event_byte) begin
        $error("event_byte: expected %h, got %h", want.event_byte, got.event_byte);
        errors++;
      end
      if (got.self_closing !== want.self_closing) begin
        $error("self_closing: expected %b, got %b", want.self_closing, got.self_closing);
        errors++;
      end
      if (got.out_last !== want.out_last) begin
        $error("out_last: expected %b, got %b", want.out_last, got.out_last);
        errors++;
      end
    endfunction
  endclass

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic byte_valid = 1'b0;
  logic byte_stall;
  in_item_t byte_item = '0;
  logic event_valid;
  logic event_stall = 1'b0;
  out_item_t event_item;

  html_markup_tokenizer_unit dut (
    .clk(clk), .rst(rst),
    .byte_valid(byte_valid), .byte_stall(byte_stall), .byte_item(byte_item),
    .event_valid(event_valid), .event_stall(event_stall), .event_item(event_item)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  event_scoreboard sb = new(HOLD_DEPTH_DEF);
  // While calm is set neither side idles, so the block runs back to back.
  bit calm = 0;
  int unsigned bytes_sent = 0;
  int unsigned cycle_count = 0;
  localparam int unsigned CYCLE_LIMIT = 200000;

  // Input transfers are noted and output transfers checked at the same edge
  // the block sees them.
  always @(posedge clk) begin
    if (!rst) begin
      if (byte_valid && !byte_stall) sb.note_byte(byte_item);
      if (event_valid && !event_stall) sb.check_event(event_item);
    end
  end

  // While calm is clear, the receiver stalls at random with a chance of about 38 in a hundred.
  always @(posedge clk) begin
    if (rst) event_stall <= 1'b0;
    else event_stall <= !calm && ($urandom_range(99) < 38);
  end

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("== FAIL ==");
      $finish;
    end
  end

  // Offer one byte, with random idle cycles in front, and hold it until the
  // transfer completes. Valid stays high after the transfer so that the next
  // byte can follow at once; idle cycles drop it.
  task automatic send_byte(logic [7:0] b, logic last);
    while (!calm && $urandom_range(99) < 38) begin
      byte_valid <= 1'b0;
      @(posedge clk);
    end
    byte_valid <= 1'b1;
    byte_item <= '{in_byte: b, in_last: last};
    @(posedge clk);
    while (byte_stall) @(posedge clk);
    bytes_sent++;
  endtask

  task automatic send_text(string s, bit last_at_end);
    for (int i = 0; i < s.len(); i++)
      send_byte(s[i], last_at_end && (i == s.len() - 1));
  endtask

  // Random bytes are mostly drawn from the characters that steer the tokenizer.
  function automatic logic [7:0] pick_byte();
    string alphabet;
    alphabet = "<>/!-=\"' \t\n\r\faZDdOCTYPEtypex&";
    if ($urandom_range(99) < 15) return 8'($urandom_range(255));
    return alphabet[$urandom_range(alphabet.len() - 1)];
  endfunction

  // A random fragment: mostly well-formed markup with random content.
  task automatic send_fragment();
    string frag;
    int sel;
    sel = $urandom_range(9);
    case (sel)
      0: frag = "<a href=\"x y\" b='q' c=v d/>";
      1: frag = "<!-- c --- d -->";
      2: frag = "<!DocType  html   \t\n\n\n\n\n\n\n\n\n\n >";
      3: frag = "</Tag >";
      4: frag = "<p =v w>";
      5: frag = "<!DOCTYPX";
      6: frag = "hi & there";
      default: frag = "";
    endcase
    if (frag.len() > 0) begin
      for (int i = 0; i < frag.len(); i++) begin
        if ($urandom_range(99) < 8) send_byte(pick_byte(), 1'b0);
        else send_byte(frag[i], 1'b0);
      end
    end else begin
      for (int i = 0; i < $urandom_range(8, 1); i++) send_byte(pick_byte(), 1'b0);
    end
    if ($urandom_range(99) < 12) send_byte(pick_byte(), 1'b1);
  endtask

  initial begin
    repeat (7) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Directed part: all token types but end tags, the fallbacks and end of input inside a tag or a "<!" lookahead.
    send_text("<B x=1/>", 0);
    send_text("<!--a--->x", 0);
    send_text("<!doctype \t a  \n>", 0);
    send_text("<1</ \000\377", 0);
    send_text("<!dox<a =\"\" z", 1);
    send_text("<!-", 1);

    // Random part, with a stretch where neither side idles.
    while (bytes_sent < 295) begin
      calm = (bytes_sent > 150 && bytes_sent < 200);
      send_fragment();
    end
    calm = 0;
    send_byte(8'h00, 1'b1);
    send_byte(8'hFF, 1'b1);
    byte_valid <= 1'b0;

    while (sb.pending_events.size() > 0) @(posedge clk);
    repeat (20) @(posedge clk);
    $display("Sent %0d bytes and checked %0d events covering text, tags, attributes,",
             bytes_sent, sb.events_seen);
    $display("comments, doctypes and end-of-input cleanup under random stalls.");
    if (sb.errors == 0 && sb.pending_events.size() == 0) $display("== PASS ==");
    else $display("== FAIL ==");
    $finish;
  end
endmodule

// ===== sim.f =====
rtl/htok_pkg.sv
rtl/htok_front.sv
rtl/htok_queue.sv
rtl/htok_back.sv
rtl/html_markup_tokenizer_unit.sv
rtl/htok_checker.sv
tb/tb_top.sv
